### src/ipv6f_pkg.sv
// ipv6f_pkg: shared types, character codes and helpers of the ipv6 text formatter
// no dependencies
package ipv6f_pkg;

  localparam int GROUP_COUNT = 8;
  localparam int GROUP_W     = 16;
  localparam int GIDX_W      = $clog2(GROUP_COUNT);
  localparam int RUN_W       = $clog2(GROUP_COUNT + 1);
  localparam int CHAR_W      = 7;

  localparam logic [RUN_W-1:0] MIN_RUN   = RUN_W'(2);
  localparam logic [RUN_W-1:0] RUN_LIMIT = RUN_W'(GROUP_COUNT);
  localparam logic [GIDX_W-1:0] LAST_GROUP = GIDX_W'(GROUP_COUNT - 1);

  localparam logic [CHAR_W-1:0] CH_COLON = 7'h3A;
  localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_UPPER = 7'h41;
  localparam logic [CHAR_W-1:0] CH_LOWER = 7'h61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLAN,
    ST_DIGIT,
    ST_COLON,
    ST_DC1,
    ST_DC2,
    ST_TERM
  } state_t;

  // position of the leading nonzero digit, zero for a zero group
  function automatic logic [1:0] lead_pos(input logic [GROUP_W-1:0] g);
    logic [1:0] p;
    if (g[15:12] != 4'h0) p = 2'd3;
    else if (g[11:8] != 4'h0) p = 2'd2;
    else if (g[7:4] != 4'h0) p = 2'd1;
    else p = 2'd0;
    return p;
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) c = CH_ZERO + {3'b000, d};
    else c = (upper ? CH_UPPER : CH_LOWER) + {3'b000, d} - 7'd10;
    return c;
  endfunction

endpackage

### src/ipv6_compressed_text_formatter.sv
// ipv6_compressed_text_formatter: ipv6 address to compressed text, one character per transfer
// depends on ipv6f_pkg
//
// channel  signals                                          role
// in       in_valid in_ready addr_upper addr_lower
//          append_terminator                                one address per transfer
// out      out_valid out_ready out_char last_char           one character per transfer
// cfg      cfg_valid cfg_ready cfg_data                     uppercase_digits register
//
// an address passes through a take step, the zero run scan (one group a cycle
// through one compare unit) and a planning step, then leaves as n characters (2 to 40),
// one character a cycle from the output register while out is not stalled.
// a stall on out holds the sequencer; in_ready is high only between addresses.
// rst is synchronous; it clears the sequencer and output valid and sets uppercase.
module ipv6_compressed_text_formatter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [63:0]                      addr_upper,
  input  logic [63:0]                      addr_lower,
  input  logic                             append_terminator,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ipv6f_pkg::CHAR_W-1:0]     out_char,
  output logic                             last_char,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_data
);

  localparam int GW  = ipv6f_pkg::GROUP_W;
  localparam int IW  = ipv6f_pkg::GIDX_W;
  localparam int RW  = ipv6f_pkg::RUN_W;

  ipv6f_pkg::state_t state, state_next;

  logic [127:0]  addr;
  logic          term;
  logic          upper;
  logic [IW-1:0] gi, gi_next;
  logic [1:0]    pos, pos_next;
  logic [RW-1:0] run, run_next;
  logic [IW-1:0] run_start, run_start_next;
  logic [RW-1:0] best, best_next;
  logic [IW-1:0] best_start, best_start_next;

  logic [GW-1:0] cur_grp;
  logic [GW-1:0] start_grp;
  logic [IW-1:0] sidx;
  logic          do_start;
  logic          compressed;
  logic [RW-1:0] right_start;
  logic          adv;
  logic          emit;
  logic [ipv6f_pkg::CHAR_W-1:0] ch;
  logic          ch_last;
  logic [3:0]    nib;

  assign in_ready    = (state == ipv6f_pkg::ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign compressed  = (best >= ipv6f_pkg::MIN_RUN);
  assign right_start = {1'b0, best_start} + best;
  assign adv         = !out_valid || out_ready;

  assign cur_grp   = addr[(IW'(ipv6f_pkg::LAST_GROUP) - gi) * GW +: GW];
  assign start_grp = addr[(IW'(ipv6f_pkg::LAST_GROUP) - sidx) * GW +: GW];
  assign nib       = cur_grp[{pos, 2'b00} +: 4];

  // next state and sequencer counters
  always_comb begin
    state_next      = state;
    gi_next         = gi;
    pos_next        = pos;
    run_next        = run;
    run_start_next  = run_start;
    best_next       = best;
    best_start_next = best_start;
    do_start        = 1'b0;
    sidx            = gi;
    case (state)
      ipv6f_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = ipv6f_pkg::ST_SCAN;
          gi_next    = '0;
          run_next   = '0;
          best_next  = '0;
        end
      end
      ipv6f_pkg::ST_SCAN: begin
        if (cur_grp == '0) begin
          run_next = run + RW'(1);
          if (run == '0) run_start_next = gi;
          if (run + RW'(1) > best) begin
            best_next       = run + RW'(1);
            best_start_next = (run == '0) ? gi : run_start;
          end
        end else begin
          run_next = '0;
        end
        if (gi == ipv6f_pkg::LAST_GROUP) state_next = ipv6f_pkg::ST_PLAN;
        else gi_next = gi + IW'(1);
      end
      ipv6f_pkg::ST_PLAN: begin
        do_start = 1'b1;
        sidx     = '0;
      end
      ipv6f_pkg::ST_DIGIT: begin
        if (adv) begin
          if (pos != 2'd0) begin
            pos_next = pos - 2'd1;
          end else if (gi == ipv6f_pkg::LAST_GROUP) begin
            state_next = term ? ipv6f_pkg::ST_TERM : ipv6f_pkg::ST_IDLE;
          end else if (compressed && (gi + IW'(1) == best_start)) begin
            state_next = ipv6f_pkg::ST_DC1;
          end else begin
            state_next = ipv6f_pkg::ST_COLON;
          end
        end
      end
      ipv6f_pkg::ST_COLON: begin
        if (adv) begin
          do_start = 1'b1;
          sidx     = gi + IW'(1);
        end
      end
      ipv6f_pkg::ST_DC1: begin
        if (adv) state_next = ipv6f_pkg::ST_DC2;
      end
      ipv6f_pkg::ST_DC2: begin
        if (adv) begin
          if (right_start == ipv6f_pkg::RUN_LIMIT) begin
            state_next = term ? ipv6f_pkg::ST_TERM : ipv6f_pkg::ST_IDLE;
          end else begin
            do_start = 1'b1;
            sidx     = right_start[IW-1:0];
          end
        end
      end
      ipv6f_pkg::ST_TERM: begin
        if (adv) state_next = ipv6f_pkg::ST_IDLE;
      end
      default: state_next = ipv6f_pkg::ST_IDLE;
    endcase
    if (do_start) begin
      gi_next = sidx;
      if (compressed && (sidx == best_start)) begin
        state_next = ipv6f_pkg::ST_DC1;
      end else begin
        state_next = ipv6f_pkg::ST_DIGIT;
        pos_next   = ipv6f_pkg::lead_pos(start_grp);
      end
    end
  end

  // character of the current step
  always_comb begin
    emit    = 1'b0;
    ch      = ipv6f_pkg::CH_NUL;
    ch_last = 1'b0;
    case (state)
      ipv6f_pkg::ST_DIGIT: begin
        emit    = 1'b1;
        ch      = ipv6f_pkg::hex_char(nib, upper);
        ch_last = (pos == 2'd0) && (gi == ipv6f_pkg::LAST_GROUP) && !term;
      end
      ipv6f_pkg::ST_COLON, ipv6f_pkg::ST_DC1: begin
        emit = 1'b1;
        ch   = ipv6f_pkg::CH_COLON;
      end
      ipv6f_pkg::ST_DC2: begin
        emit    = 1'b1;
        ch      = ipv6f_pkg::CH_COLON;
        ch_last = (right_start == ipv6f_pkg::RUN_LIMIT) && !term;
      end
      ipv6f_pkg::ST_TERM: begin
        emit    = 1'b1;
        ch      = ipv6f_pkg::CH_NUL;
        ch_last = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ipv6f_pkg::ST_IDLE;
      out_valid <= 1'b0;
      upper     <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) upper <= cfg_data;
      if (emit && adv) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    gi         <= gi_next;
    pos        <= pos_next;
    run        <= run_next;
    run_start  <= run_start_next;
    best       <= best_next;
    best_start <= best_start_next;
    if (in_valid && in_ready) begin
      addr <= {addr_upper, addr_lower};
      term <= append_terminator;
    end
    if (emit && adv) begin
      out_char  <= ch;
      last_char <= ch_last;
    end
  end

`ifndef ASSERT_OFF
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ipv6f_pkg::ST_SCAN && gi == '0)
    else $error("transfer in did not start the scan");

  a_dc_needs_run: assert property (@(posedge clk) disable iff (rst)
    state == ipv6f_pkg::ST_DC1 |-> best >= ipv6f_pkg::MIN_RUN)
    else $error("double colon without a zero run");

  a_run_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ipv6f_pkg::ST_PLAN |-> right_start <= ipv6f_pkg::RUN_LIMIT)
    else $error("zero run past the last group");

  a_term_last: assert property (@(posedge clk) disable iff (rst)
    state == ipv6f_pkg::ST_TERM && adv |=>
      out_valid && last_char && out_char == ipv6f_pkg::CH_NUL)
    else $error("terminator not flagged as last");
`endif

endmodule
